@@ rtl/nau_pkg.sv @@
package nau_pkg;

  localparam int OP_W      = 2;
  localparam int OPERAND_W = 16;
  localparam int RESULT_W  = 15;

  localparam logic [OP_W-1:0] OP_RELU       = 2'd0;
  localparam logic [OP_W-1:0] OP_RELU_DERIV = 2'd1;
  localparam logic [OP_W-1:0] OP_SIGMOID    = 2'd2;
  localparam logic [OP_W-1:0] OP_SIG_DERIV  = 2'd3;

  // control that travels alongside the sigmoid datapath
  typedef struct packed {
    logic                valid;
    logic [OP_W-1:0]     op;
    logic [RESULT_W-1:0] relu;
  } ctl_t;

  // restoring long division, only ever evaluated while building the ROM
  function automatic longint unsigned udiv64(input longint unsigned num,
                                             input longint unsigned den);
    longint unsigned quo;
    longint unsigned rem;
    quo = 64'd0;
    rem = 64'd0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // sigmoid sample at x = 8k/2^tb, Q(fb); e^(-8/N) from a Taylor sum through the 24th power in Q30
  function automatic longint unsigned rom_entry(input int tb, input int fb, input int k);
    longint unsigned q30;
    longint unsigned h;
    longint unsigned term;
    longint          sum;
    longint unsigned eh;
    longint unsigned e;
    longint unsigned denom;
    q30  = 64'd1 << 30;
    h    = (64'd8 << 30) >> tb;
    term = q30;
    sum  = longint'(q30);
    for (int i = 1; i <= 24; i++) begin
      term = udiv64((term * h + (64'd1 << 29)) >> 30, longint'(i));
      if (i % 2 == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    eh = (sum > 0) ? longint'(sum) : 64'd0;
    e  = q30;
    for (int j = 1; j <= k; j++) begin
      e = (e * eh + (64'd1 << 29)) >> 30;
    end
    denom = q30 + e;
    return udiv64((64'd1 << (fb + 30)) + (denom >> 1), denom);
  endfunction

endpackage

@@ rtl/neural_activation_unit_core.sv @@
// channel  handshake     fields                             notes
// request  start / busy  opcode[1:0], operand_value[15:0]   taken when start & !busy
// result   done          result_value[14:0]                 one-cycle strobe, no stall
//
// One request per cycle; seven register stages (input register, four sigmoid
// stages, derivative multiply, output register); done leaves the output register.
// busy stays low: the pipeline never stalls since results cannot be held off.
// rst is synchronous and clears only the valid bits.
module neural_activation_unit_core #(
  parameter int TABLE_BITS = 6,
  parameter int FRAC_BITS  = 12
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [nau_pkg::OP_W-1:0]             opcode,
  input  logic signed [nau_pkg::OPERAND_W-1:0] operand_value,
  output logic                                 done,
  output logic [nau_pkg::RESULT_W-1:0]         result_value
);

  localparam int ONE = 1 << FRAC_BITS;
  localparam int DW  = 2 * (FRAC_BITS + 1);
  localparam int RW  = nau_pkg::RESULT_W;

  assign busy = 1'b0;

  // input register; relu and its derivative are settled here
  logic          pos;
  logic [RW-1:0] relu_in;
  nau_pkg::ctl_t ctl0;
  logic signed [nau_pkg::OPERAND_W-1:0] z0;

  always_comb begin
    pos = !operand_value[nau_pkg::OPERAND_W-1] && (operand_value != '0);
    if (!pos) begin
      relu_in = '0;
    end else if (opcode == nau_pkg::OP_RELU_DERIV) begin
      relu_in = RW'(ONE);
    end else begin
      relu_in = operand_value[RW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl0.valid <= 1'b0;
    end else begin
      ctl0.valid <= start && !busy;
    end
    ctl0.op   <= opcode;
    ctl0.relu <= relu_in;
    z0        <= operand_value;
  end

  nau_pkg::ctl_t      ctl4;
  logic [FRAC_BITS:0] sig4;

  nau_sigmoid #(
    .TABLE_BITS(TABLE_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_sigmoid (
    .clk    (clk),
    .rst    (rst),
    .in_ctl (ctl0),
    .z      (z0),
    .out_ctl(ctl4),
    .sig    (sig4)
  );

  // s * (1 - s)
  nau_pkg::ctl_t      ctl5;
  logic [FRAC_BITS:0] sig5;
  logic [DW-1:0]      dprod5;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl5.valid <= 1'b0;
    end else begin
      ctl5.valid <= ctl4.valid;
    end
    ctl5.op   <= ctl4.op;
    ctl5.relu <= ctl4.relu;
    sig5      <= sig4;
    dprod5    <= DW'(sig4) * DW'((FRAC_BITS+1)'(ONE) - sig4);
  end

  // round the derivative and pick the result
  logic [DW-1:0] deriv;
  logic [RW-1:0] result_next;

  always_comb begin
    deriv = (dprod5 + DW'(ONE >> 1)) >> FRAC_BITS;
    case (ctl5.op)
      nau_pkg::OP_RELU:       result_next = ctl5.relu;
      nau_pkg::OP_RELU_DERIV: result_next = ctl5.relu;
      nau_pkg::OP_SIGMOID:    result_next = RW'(sig5);
      nau_pkg::OP_SIG_DERIV:  result_next = deriv[RW-1:0];
      default:                result_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl5.valid;
    end
  end

  always_ff @(posedge clk) begin
    result_value <= result_next;
  end

`ifndef SYNTHESIS
  a_sig_range: assert property (@(posedge clk) disable iff (rst)
    ctl5.valid |-> sig5 <= (FRAC_BITS+1)'(ONE))
    else $error("sigmoid above 1.0");

  a_relu_deriv: assert property (@(posedge clk) disable iff (rst)
    ctl5.valid && ctl5.op == nau_pkg::OP_RELU_DERIV |=>
      result_value == '0 || result_value == RW'(ONE))
    else $error("relu derivative not 0 or 1.0");

  a_sig_deriv: assert property (@(posedge clk) disable iff (rst)
    ctl5.valid && ctl5.op == nau_pkg::OP_SIG_DERIV |=>
      done && result_value <= RW'(ONE >> 2))
    else $error("sigmoid derivative above 0.25 or strobe missing");
`endif

endmodule

@@ rtl/nau_sigmoid.sv @@
module nau_sigmoid #(
  parameter int TABLE_BITS = 6,
  parameter int FRAC_BITS  = 12
) (
  input  logic                             clk,
  input  logic                             rst,
  input  nau_pkg::ctl_t                    in_ctl,
  input  logic signed [nau_pkg::OPERAND_W-1:0] z,
  output nau_pkg::ctl_t                    out_ctl,
  output logic [FRAC_BITS:0]               sig
);

  localparam int ROM_N = 1 << TABLE_BITS;
  localparam int SEG   = FRAC_BITS + 3 - TABLE_BITS;
  localparam int AW    = FRAC_BITS + 3;
  localparam int MW    = nau_pkg::OPERAND_W + 1;
  localparam int LIMIT = (1 << AW) - 1;
  localparam int ONE   = 1 << FRAC_BITS;
  localparam int PW    = FRAC_BITS + 1 + SEG;

  logic [FRAC_BITS:0] rom [ROM_N+1];

  for (genvar k = 0; k <= ROM_N; k++) begin : g_rom
    localparam longint unsigned ENTRY = nau_pkg::rom_entry(TABLE_BITS, FRAC_BITS, k);
    assign rom[k] = ENTRY[FRAC_BITS:0];
  end

  // stage 1: magnitude, saturate, split into segment and offset
  logic [MW-1:0]         mag;
  logic [AW-1:0]         a_sat;
  nau_pkg::ctl_t         ctl1;
  logic                  neg1;
  logic [TABLE_BITS-1:0] idx1;
  logic [SEG-1:0]        frac1;

  always_comb begin
    mag = z[nau_pkg::OPERAND_W-1] ? MW'(-{z[nau_pkg::OPERAND_W-1], z}) : MW'({1'b0, z});
    if ({1'b0, mag} > (MW+1)'(LIMIT)) begin
      a_sat = AW'(LIMIT);
    end else begin
      a_sat = mag[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl1.valid <= 1'b0;
    end else begin
      ctl1.valid <= in_ctl.valid;
    end
    ctl1.op   <= in_ctl.op;
    ctl1.relu <= in_ctl.relu;
    neg1      <= z[nau_pkg::OPERAND_W-1];
    idx1      <= a_sat[AW-1:SEG];
    frac1     <= a_sat[SEG-1:0];
  end

  // stage 2: table lookup of both segment ends
  logic [FRAC_BITS:0] lo;
  logic [FRAC_BITS:0] hi;
  nau_pkg::ctl_t      ctl2;
  logic               neg2;
  logic [FRAC_BITS:0] lo2;
  logic [FRAC_BITS:0] diff2;
  logic [SEG-1:0]     frac2;

  always_comb begin
    lo = rom[{1'b0, idx1}];
    hi = rom[(TABLE_BITS+1)'({1'b0, idx1}) + (TABLE_BITS+1)'(1)];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl2.valid <= 1'b0;
    end else begin
      ctl2.valid <= ctl1.valid;
    end
    ctl2.op   <= ctl1.op;
    ctl2.relu <= ctl1.relu;
    neg2      <= neg1;
    lo2       <= lo;
    diff2     <= (hi >= lo) ? hi - lo : '0;
    frac2     <= frac1;
  end

  // stage 3: slope times offset
  nau_pkg::ctl_t      ctl3;
  logic               neg3;
  logic [FRAC_BITS:0] lo3;
  logic [PW-1:0]      prod3;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl3.valid <= 1'b0;
    end else begin
      ctl3.valid <= ctl2.valid;
    end
    ctl3.op   <= ctl2.op;
    ctl3.relu <= ctl2.relu;
    neg3      <= neg2;
    lo3       <= lo2;
    prod3     <= PW'(diff2) * PW'(frac2);
  end

  // stage 4: round, add, clamp at 1.0, mirror for negative z
  logic [PW:0]          rnd_full;
  logic [FRAC_BITS+1:0] s_sum;
  logic [FRAC_BITS:0]   s_clamp;
  logic [FRAC_BITS:0]   s_final;

  always_comb begin
    rnd_full = ({1'b0, prod3} + (PW+1)'(1 << (SEG - 1))) >> SEG;
    s_sum    = (FRAC_BITS+2)'(lo3) + (FRAC_BITS+2)'(rnd_full[FRAC_BITS:0]);
    if (s_sum > (FRAC_BITS+2)'(ONE)) begin
      s_clamp = (FRAC_BITS+1)'(ONE);
    end else begin
      s_clamp = s_sum[FRAC_BITS:0];
    end
    s_final = neg3 ? (FRAC_BITS+1)'(ONE) - s_clamp : s_clamp;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ctl.valid <= 1'b0;
    end else begin
      out_ctl.valid <= ctl3.valid;
    end
    out_ctl.op   <= ctl3.op;
    out_ctl.relu <= ctl3.relu;
    sig          <= s_final;
  end

endmodule

@@ verif/neural_activation_unit_core_test.sv @@
module neural_activation_unit_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_BITS = 6;
  localparam int FRAC_BITS = 12;
  localparam int TABLE_N = 1 << TABLE_BITS;
  localparam int SEG_SHIFT = FRAC_BITS + 3 - TABLE_BITS;
  localparam int unsigned ONE = 1 << FRAC_BITS;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 20;

  typedef struct {
    logic [nau_pkg::OP_W-1:0]             op;
    logic signed [nau_pkg::OPERAND_W-1:0] z;
    logic [nau_pkg::RESULT_W-1:0]         value;
  } activation_t;

  logic                                 clk = 1'b0;
  logic                                 rst = 1'b1;
  logic                                 start = 1'b0;
  logic                                 busy;
  logic [nau_pkg::OP_W-1:0]             opcode = '0;
  logic signed [nau_pkg::OPERAND_W-1:0] operand_value = '0;
  logic                                 done;
  logic [nau_pkg::RESULT_W-1:0]         result_value;

  activation_t     pending_results[$];
  longint unsigned sigmoid_table[TABLE_N+1];
  int unsigned     error_count = 0;
  int unsigned     cycle_count = 0;

  neural_activation_unit_core #(
    .TABLE_BITS(TABLE_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .opcode       (opcode),
    .operand_value(operand_value),
    .done         (done),
    .result_value (result_value)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // sigmoid samples at x = 8k/N, Q(FRAC_BITS); e^(-8/N) from a Taylor series in Q30
  function automatic void build_sigmoid_table();
    longint unsigned step_q30;
    longint unsigned term;
    longint unsigned decay;
    longint unsigned e;
    longint unsigned denom;
    longint          series;
    step_q30 = (64'd8 << 30) >> TABLE_BITS;
    term = 64'd1 << 30;
    series = longint'(64'd1 << 30);
    for (int i = 1; i <= 24; i++) begin
      term = ((term * step_q30 + (64'd1 << 29)) >> 30) / longint'(i);
      if (i % 2 == 1) begin
        series = series - longint'(term);
      end else begin
        series = series + longint'(term);
      end
    end
    decay = (series > 0) ? longint'(series) : 64'd0;
    e = 64'd1 << 30;
    for (int k = 0; k <= TABLE_N; k++) begin
      if (k > 0) begin
        e = (e * decay + (64'd1 << 29)) >> 30;
      end
      denom = (64'd1 << 30) + e;
      sigmoid_table[k] = ((longint'(ONE) << 30) + denom / 2) / denom;
    end
  endfunction

  function automatic int unsigned sigmoid_fixed(input int zi);
    int unsigned mag;
    int unsigned idx;
    int unsigned frac;
    int unsigned lo;
    int unsigned hi;
    int unsigned s;
    mag = (zi < 0) ? -zi : zi;
    // -8.0 has no positive twin, so clamp just below 8
    if (mag > 8 * ONE - 1) begin
      mag = 8 * ONE - 1;
    end
    idx = (mag >> SEG_SHIFT) & (TABLE_N - 1);
    frac = mag & ((1 << SEG_SHIFT) - 1);
    lo = int'(sigmoid_table[idx]);
    hi = int'(sigmoid_table[idx + 1]);
    if (hi >= lo) begin
      s = lo + (((hi - lo) * frac + (1 << (SEG_SHIFT - 1))) >> SEG_SHIFT);
    end else begin
      s = lo;
    end
    if (s > ONE) begin
      s = ONE;
    end
    return (zi < 0) ? ONE - s : s;
  endfunction

  function automatic logic [nau_pkg::RESULT_W-1:0] predict_activation(
    input logic [nau_pkg::OP_W-1:0] op, input logic signed [nau_pkg::OPERAND_W-1:0] z);
    int              zi;
    int unsigned     s;
    longint unsigned r;
    zi = int'(z);
    case (op)
      nau_pkg::OP_RELU: begin
        r = (zi > 0) ? zi : 0;
      end
      nau_pkg::OP_RELU_DERIV: begin
        r = (zi > 0) ? ONE : 0;
      end
      nau_pkg::OP_SIGMOID: begin
        r = sigmoid_fixed(zi);
      end
      nau_pkg::OP_SIG_DERIV: begin
        s = sigmoid_fixed(zi);
        r = (longint'(s) * longint'(ONE - s) + ONE / 2) >> FRAC_BITS;
      end
      default: begin
        r = 0;
      end
    endcase
    return r[nau_pkg::RESULT_W-1:0];
  endfunction

  task automatic send_request(input logic [nau_pkg::OP_W-1:0] op,
                              input logic signed [nau_pkg::OPERAND_W-1:0] z);
    activation_t req;
    start <= 1'b1;
    opcode <= op;
    operand_value <= z;
    do @(posedge clk); while (busy);
    req.op = op;
    req.z = z;
    req.value = predict_activation(op, z);
    pending_results.push_back(req);
  endtask

  task automatic hold_off(input int cycles);
    if (cycles > 0) begin
      start <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  task automatic wait_for_drain();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // zero, +-one lsb, both extremes (-8.0 saturates the sigmoid), first segment edge
  task automatic test_corner_cases();
    logic signed [nau_pkg::OPERAND_W-1:0] corners[6];
    corners[0] = 16'sh0000;
    corners[1] = 16'sh0001;
    corners[2] = 16'shFFFF;
    corners[3] = 16'sh7FFF;
    corners[4] = 16'sh8000;
    corners[5] = 16'sh0200;
    for (int o = 0; o < 4; o++) begin
      for (int c = 0; c < 6; c++) begin
        send_request(o[nau_pkg::OP_W-1:0], corners[c]);
      end
    end
  endtask

  task automatic test_random_traffic(input int count, input int idle_pct);
    int                                   pick;
    int                                   zi;
    logic [nau_pkg::OP_W-1:0]             op;
    logic signed [nau_pkg::OPERAND_W-1:0] z;
    for (int n = 0; n < count; n++) begin
      op = $urandom_range(3);
      pick = $urandom_range(9);
      if (pick < 6) begin
        zi = $urandom;
      end else if (pick < 8) begin
        zi = int'($urandom_range(2048)) - 1024;
      end else begin
        // around table segment edges
        zi = int'($urandom_range(TABLE_N - 1)) * (1 << SEG_SHIFT)
             + int'($urandom_range(2)) - 1;
        if ($urandom_range(1) == 1) begin
          zi = -zi;
        end
      end
      z = zi[nau_pkg::OPERAND_W-1:0];
      send_request(op, z);
      // each cycle idles with probability idle_pct
      while ($urandom_range(99) < idle_pct) begin
        hold_off(1);
      end
    end
  endtask

  always @(posedge clk) begin
    activation_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual %0d", $time, result_value);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (result_value !== want.value) begin
          $display("%0t: op %0d z %0d: result_value expected %0d, actual %0d",
                   $time, want.op, want.z, want.value, result_value);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    build_sigmoid_table();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_corner_cases();
    wait_for_drain();
    test_random_traffic(550, 18);
    // let the pipe empty completely before resuming
    wait_for_drain();
    test_random_traffic(550, 80);
    test_random_traffic(550, 0);
    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
